/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// Condition must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

/* hw/rtl/admm_pkg.sv */
`timescale 1ns / 1ps
package admm_pkg;

  // IEEE single constants
  localparam logic [31:0] FP_ONE         = 32'h3F80_0000;
  localparam logic [31:0] FP_ZERO        = 32'h0000_0000;
  localparam logic [31:0] FP_DEFAULT_NAN = 32'hFFC0_0000;
  localparam logic [31:0] FP_QUIET_BIT   = 32'h0040_0000;

  // register reset values
  localparam logic [31:0] RHO_RESET   = 32'h0000_0000;
  localparam logic [31:0] ALPHA_RESET = 32'h3F80_0000;
  localparam logic [6:0]  DIMENSION_RESET = 7'd64;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_RHO       = 2'd0,
    CFG_ALPHA     = 2'd1,
    CFG_DIMENSION = 2'd2
  } cfg_reg_t;

  // arithmetic unit operations
  typedef enum logic [1:0] {
    FOP_ADD = 2'd0,
    FOP_SUB = 2'd1,
    FOP_MUL = 2'd2
  } fop_t;

  // operand sources
  typedef enum logic [3:0] {
    SRC_MAT   = 4'd0,
    SRC_W     = 4'd1,
    SRC_X     = 4'd2,
    SRC_Z     = 4'd3,
    SRC_ZOLD  = 4'd4,
    SRC_U     = 4'd5,
    SRC_Q     = 4'd6,
    SRC_ALPHA = 4'd7,
    SRC_BETA  = 4'd8,
    SRC_RHO   = 4'd9,
    SRC_ONE   = 4'd10,
    SRC_ACC   = 4'd11,
    SRC_TMP   = 4'd12,
    SRC_XH    = 4'd13,
    SRC_V     = 4'd14,
    SRC_ZR    = 4'd15
  } src_t;

  // scalar destinations
  typedef enum logic [2:0] {
    DST_NONE = 3'd0,
    DST_ACC  = 3'd1,
    DST_TMP  = 3'd2,
    DST_XH   = 3'd3,
    DST_V    = 3'd4,
    DST_ZR   = 3'd5,
    DST_BETA = 3'd6
  } dst_t;

  // controller to datapath
  typedef struct packed {
    fop_t op;
    src_t src_a;
    src_t src_b;
    logic neg_a;
    dst_t dst;
    logic clamp;
    logic start;
    logic clr_acc;
    logic first;
    logic we_w;
    logic we_x;
    logic we_z;
    logic we_zold;
    logic we_u;
    logic load;
    logic out_load;
    logic out_last;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic fpu_done;
    logic out_free;
  } stat_t;

endpackage

/* hw/rtl/admm_fpu.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Five-stage IEEE single add/sub/multiply, round to nearest even.
module admm_fpu (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  admm_pkg::fop_t    op,
  input  logic [31:0]       a,
  input  logic [31:0]       b,
  output logic              done,
  output logic [31:0]       result
);
  import admm_pkg::*;

  logic [3:0] v;

  // ---------------- stage 1: unpack, special cases, align or multiply
  logic              sa, sb, sbe;
  logic [7:0]        ea, eb;
  logic [22:0]       fa, fb;
  logic              nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
  logic [23:0]       ma, mb, m_big, m_sml;
  logic signed [9:0] xa, xb, x_big, x_sml;
  logic              swap, s_big;
  logic [9:0]        dshift;
  logic [47:0]       sml_full, sml_sh;
  logic              sml_st;
  logic              spec;
  logic [31:0]       specv;
  logic              is_mul;

  always_comb begin
    sa = a[31];
    sb = b[31];
    ea = a[30:23];
    eb = b[30:23];
    fa = a[22:0];
    fb = b[22:0];
    is_mul = (op == FOP_MUL);
    sbe = sb ^ (op == FOP_SUB);
    nan_a = (ea == 8'hFF) && (fa != '0);
    nan_b = (eb == 8'hFF) && (fb != '0);
    inf_a = (ea == 8'hFF) && (fa == '0);
    inf_b = (eb == 8'hFF) && (fb == '0);
    zero_a = (ea == '0) && (fa == '0);
    zero_b = (eb == '0) && (fb == '0);
    ma = {(ea != '0), fa};
    mb = {(eb != '0), fb};
    xa = (ea == '0) ? 10'sd1 : signed'({2'b00, ea});
    xb = (eb == '0) ? 10'sd1 : signed'({2'b00, eb});

    // larger magnitude goes first
    swap = (a[30:0] < b[30:0]);
    m_big = swap ? mb : ma;
    m_sml = swap ? ma : mb;
    x_big = swap ? xb : xa;
    x_sml = swap ? xa : xb;
    s_big = swap ? sbe : sa;
    dshift = unsigned'(x_big - x_sml);
    sml_full = {1'b0, m_sml, 23'b0};
    if (dshift >= 10'd48) begin
      sml_sh = '0;
      sml_st = |m_sml;
    end else begin
      sml_sh = sml_full >> dshift[5:0];
      sml_st = ((sml_sh << dshift[5:0]) != sml_full);
    end

    // special operands
    spec = 1'b1;
    specv = FP_ZERO;
    if (nan_a) begin
      specv = a | FP_QUIET_BIT;
    end else if (nan_b) begin
      specv = b | FP_QUIET_BIT;
    end else if (is_mul) begin
      priority if ((inf_a && zero_b) || (zero_a && inf_b)) begin
        specv = FP_DEFAULT_NAN;
      end else if (inf_a || inf_b) begin
        specv = {sa ^ sb, 8'hFF, 23'b0};
      end else if (zero_a || zero_b) begin
        specv = {sa ^ sb, 31'b0};
      end else begin
        spec = 1'b0;
      end
    end else begin
      priority if (inf_a && inf_b && (sa != sbe)) begin
        specv = FP_DEFAULT_NAN;
      end else if (inf_a) begin
        specv = a;
      end else if (inf_b) begin
        specv = {sbe, b[30:0]};
      end else if (zero_a && zero_b) begin
        specv = {sa & sbe, 31'b0};
      end else if (zero_a) begin
        specv = {sbe, b[30:0]};
      end else if (zero_b) begin
        specv = a;
      end else begin
        spec = 1'b0;
      end
    end
  end

  logic              s1_spec, s1_sign, s1_mul, s1_sub;
  logic [31:0]       s1_specv;
  logic signed [9:0] s1_exp;
  logic [47:0]       s1_big, s1_sml, s1_prod;

  always_ff @(posedge clk) begin
    s1_spec  <= spec;
    s1_specv <= specv;
    s1_mul   <= is_mul;
    s1_sub   <= (s_big != (swap ? sa : sbe));
    s1_sign  <= is_mul ? (sa ^ sb) : s_big;
    s1_exp   <= is_mul ? (xa + xb - 10'sd127) : x_big;
    s1_big   <= {1'b0, m_big, 23'b0};
    s1_sml   <= sml_sh | {47'b0, sml_st};
    s1_prod  <= ma * mb;
  end

  // ---------------- stage 2: mantissa add or subtract, or pass the product
  logic              s2_spec, s2_sign;
  logic [31:0]       s2_specv;
  logic signed [9:0] s2_exp;
  logic [47:0]       s2_m;

  always_ff @(posedge clk) begin
    s2_spec  <= s1_spec;
    s2_specv <= s1_specv;
    s2_sign  <= s1_sign;
    s2_exp   <= s1_exp;
    if (s1_mul) begin
      s2_m <= s1_prod;
    end else if (s1_sub) begin
      s2_m <= s1_big - s1_sml;
    end else begin
      s2_m <= s1_big + s1_sml;
    end
  end

  // ---------------- stage 3: leading-zero count and left shift
  logic [5:0] lz;

  always_comb begin
    lz = 6'd0;
    for (int k = 0; k < 48; k++) begin
      if (s2_m[k]) lz = 6'(47 - k);
    end
  end

  logic              s3_spec, s3_sign;
  logic [31:0]       s3_specv;
  logic signed [9:0] s3_exp;
  logic [47:0]       s3_m;

  always_ff @(posedge clk) begin
    // exact cancellation gives +0
    s3_spec  <= s2_spec || (s2_m == '0);
    s3_specv <= s2_spec ? s2_specv : FP_ZERO;
    s3_sign  <= s2_sign;
    s3_m     <= s2_m << lz;
    s3_exp   <= s2_exp + 10'sd1 - signed'({4'b0000, lz});
  end

  // ---------------- stage 4: denormalize below the normal range
  logic [9:0]  dn_sh;
  logic [47:0] dn_m;

  always_comb begin
    dn_sh = unsigned'(10'sd1 - s3_exp);
    if (dn_sh >= 10'd48) begin
      dn_m = {47'b0, |s3_m};
    end else begin
      dn_m = (s3_m >> dn_sh[5:0]);
      dn_m[0] = dn_m[0] | ((dn_m << dn_sh[5:0]) != s3_m);
    end
  end

  logic              s4_spec, s4_sign;
  logic [31:0]       s4_specv;
  logic signed [9:0] s4_exp;
  logic [47:0]       s4_m;

  always_ff @(posedge clk) begin
    s4_spec  <= s3_spec;
    s4_specv <= s3_specv;
    s4_sign  <= s3_sign;
    if (s3_exp < 10'sd1) begin
      s4_m   <= dn_m;
      s4_exp <= 10'sd0;
    end else begin
      s4_m   <= s3_m;
      s4_exp <= s3_exp;
    end
  end

  // ---------------- stage 5: round and pack
  logic              rnd_up;
  logic [24:0]       mr;
  logic signed [9:0] ef;
  logic [22:0]       frac;
  logic [31:0]       packed_res;

  always_comb begin
    rnd_up = s4_m[23] && ((|s4_m[22:0]) || s4_m[24]);
    mr = {1'b0, s4_m[47:24]} + {24'b0, rnd_up};
    if (s4_exp == 10'sd0) begin
      ef = mr[23] ? 10'sd1 : 10'sd0;
      frac = mr[22:0];
    end else if (mr[24]) begin
      ef = s4_exp + 10'sd1;
      frac = mr[23:1];
    end else begin
      ef = s4_exp;
      frac = mr[22:0];
    end
    if (ef >= 10'sd255) begin
      packed_res = {s4_sign, 8'hFF, 23'b0};
    end else begin
      packed_res = {s4_sign, ef[7:0], frac};
    end
  end

  always_ff @(posedge clk) begin
    result <= s4_spec ? s4_specv : packed_res;
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v    <= '0;
      done <= 1'b0;
    end else begin
      v    <= {v[2:0], start};
      done <= v[3];
    end
  end

  `ASSERT_PROP(a_done_latency, clk, rst, done |-> $past(start, 5))
  `ASSERT_NEVER(a_no_overlap, clk, rst, start && (|v))

endmodule

/* hw/rtl/admm_datapath.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Stores, scalar registers, configuration registers and the arithmetic unit.
module admm_datapath #(
  parameter int DIM = 64,
  parameter int AW  = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  admm_pkg::cmd_t      cmd,
  output admm_pkg::stat_t     stat,
  input  logic [AW-1:0]       i,
  input  logic [AW-1:0]       j,
  input  logic [AW-1:0]       vaddr,
  output logic [AW:0]         n,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                load_mode,
  input  logic [5:0]          load_row,
  input  logic [5:0]          load_col,
  input  logic [31:0]         load_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [5:0]          out_index,
  output logic [31:0]         out_solution,
  output logic                out_end
);
  import admm_pkg::*;

  localparam int MDEPTH = 1 << (2 * AW);

  // configuration registers
  logic [31:0] rho, alpha;
  logic [6:0]  dimension;

  always_ff @(posedge clk) begin
    if (rst) begin
      rho       <= RHO_RESET;
      alpha     <= ALPHA_RESET;
      dimension <= DIMENSION_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_RHO:       rho <= cfg_data;
        CFG_ALPHA:     alpha <= cfg_data;
        CFG_DIMENSION: dimension <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // problem size, clamped to 1..DIM
  always_comb begin
    if (dimension == '0) begin
      n = (AW + 1)'(1);
    end else if (dimension > 7'(DIM)) begin
      n = (AW + 1)'(DIM);
    end else begin
      n = dimension[AW:0];
    end
  end

  // load writes, out-of-range indexes dropped
  logic row_ok, col_ok;
  assign row_ok = ({1'b0, load_row} < 7'(DIM));
  assign col_ok = ({1'b0, load_col} < 7'(DIM));

  // matrix store
  logic [31:0] mat_mem [MDEPTH];
  logic [31:0] mat_rd;

  always_ff @(posedge clk) begin
    if (cmd.load && !load_mode && row_ok && col_ok) begin
      mat_mem[{load_row[AW-1:0], load_col[AW-1:0]}] <= load_value;
    end
    mat_rd <= mat_mem[{i, j}];
  end

  // q store
  logic [31:0] q_mem [DIM];
  logic [31:0] q_rd;

  always_ff @(posedge clk) begin
    if (cmd.load && load_mode && row_ok) begin
      q_mem[load_row[AW-1:0]] <= load_value;
    end
    q_rd <= q_mem[vaddr];
  end

  // arithmetic unit
  logic [31:0] opa, opb, fres;
  logic        fdone;

  admm_fpu u_fpu (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.start),
    .op     (cmd.op),
    .a      (opa),
    .b      (opb),
    .done   (fdone),
    .result (fres)
  );

  // vector stores, written on completion of the unit
  logic [31:0] w_mem [DIM];
  logic [31:0] x_mem [DIM];
  logic [31:0] z_mem [DIM];
  logic [31:0] zold_mem [DIM];
  logic [31:0] u_mem [DIM];
  logic [31:0] w_rd, x_rd, z_rd, zold_rd, u_rd;
  logic [31:0] z_v, zold_v, u_v;

  // vectors read as zero in the first round of a solve
  assign z_v    = cmd.first ? FP_ZERO : z_rd;
  assign zold_v = cmd.first ? FP_ZERO : zold_rd;
  assign u_v    = cmd.first ? FP_ZERO : u_rd;

  always_ff @(posedge clk) begin
    if (fdone && cmd.we_w)    w_mem[vaddr] <= fres;
    if (fdone && cmd.we_x)    x_mem[vaddr] <= fres;
    if (fdone && cmd.we_z)    z_mem[vaddr] <= fres;
    if (fdone && cmd.we_zold) zold_mem[vaddr] <= z_v;
    if (fdone && cmd.we_u)    u_mem[vaddr] <= fres;
    w_rd    <= w_mem[vaddr];
    x_rd    <= x_mem[vaddr];
    z_rd    <= z_mem[vaddr];
    zold_rd <= zold_mem[vaddr];
    u_rd    <= u_mem[vaddr];
  end

  // scalar working registers
  logic [31:0] acc, tmp, xh, vv, zr, beta;
  logic [31:0] wres;

  // clamp keeps strictly positive values, NaN goes to zero
  always_comb begin
    wres = fres;
    if (cmd.clamp) begin
      if (fres[31] || (fres[30:0] == '0) ||
          ((fres[30:23] == 8'hFF) && (fres[22:0] != '0))) begin
        wres = FP_ZERO;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_acc) begin
      acc <= FP_ZERO;
    end else if (fdone) begin
      unique case (cmd.dst)
        DST_ACC:  acc <= wres;
        DST_TMP:  tmp <= wres;
        DST_XH:   xh <= wres;
        DST_V:    vv <= wres;
        DST_ZR:   zr <= wres;
        DST_BETA: beta <= wres;
        default: ;
      endcase
    end
  end

  // operand selection
  function automatic logic [31:0] pick(
    input src_t s, input logic [31:0] m, input logic [31:0] w,
    input logic [31:0] x, input logic [31:0] z, input logic [31:0] zo,
    input logic [31:0] u, input logic [31:0] q, input logic [31:0] al,
    input logic [31:0] be, input logic [31:0] rh, input logic [31:0] ac,
    input logic [31:0] tm, input logic [31:0] xhh, input logic [31:0] vr,
    input logic [31:0] zz);
    logic [31:0] r;
    unique case (s)
      SRC_MAT:   r = m;
      SRC_W:     r = w;
      SRC_X:     r = x;
      SRC_Z:     r = z;
      SRC_ZOLD:  r = zo;
      SRC_U:     r = u;
      SRC_Q:     r = q;
      SRC_ALPHA: r = al;
      SRC_BETA:  r = be;
      SRC_RHO:   r = rh;
      SRC_ONE:   r = FP_ONE;
      SRC_ACC:   r = ac;
      SRC_TMP:   r = tm;
      SRC_XH:    r = xhh;
      SRC_V:     r = vr;
      SRC_ZR:    r = zz;
      default:   r = FP_ZERO;
    endcase
    return r;
  endfunction

  always_comb begin
    opa = pick(cmd.src_a, mat_rd, w_rd, x_rd, z_v, zold_v, u_v, q_rd, alpha, beta,
               rho, acc, tmp, xh, vv, zr);
    opb = pick(cmd.src_b, mat_rd, w_rd, x_rd, z_v, zold_v, u_v, q_rd, alpha, beta,
               rho, acc, tmp, xh, vv, zr);
    if (cmd.neg_a) opa[31] = ~opa[31];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_index    <= 6'(vaddr);
      out_solution <= x_rd;
      out_end      <= cmd.out_last;
    end
  end

  assign stat.fpu_done = fdone;
  assign stat.out_free = !out_valid || out_ready;

  `ASSERT_PROP(a_one_store_write, clk, rst,
    $onehot0({cmd.we_w, cmd.we_x, cmd.we_z, cmd.we_zold, cmd.we_u}))

endmodule

/* hw/rtl/admm_ctrl.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Sequencer: load, solve rounds, emit.
module admm_ctrl #(
  parameter int DIM        = 64,
  parameter int ITERATIONS = 32,
  parameter int AW         = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_ready,
  input  logic [AW:0]       n,
  input  admm_pkg::stat_t   stat,
  output admm_pkg::cmd_t    cmd,
  output logic [AW-1:0]     i,
  output logic [AW-1:0]     j,
  output logic [AW-1:0]     vaddr
);
  import admm_pkg::*;

  localparam int ITW = (ITERATIONS > 1) ? $clog2(ITERATIONS) : 1;

  typedef enum logic [16:0] {
    ST_IDLE = 17'h00001,
    ST_BETA = 17'h00002,
    ST_W    = 17'h00004,
    ST_XCLR = 17'h00008,
    ST_XMUL = 17'h00010,
    ST_XACC = 17'h00020,
    ST_XQ   = 17'h00040,
    ST_Z1   = 17'h00080,
    ST_Z2   = 17'h00100,
    ST_Z3   = 17'h00200,
    ST_Z4   = 17'h00400,
    ST_Z5   = 17'h00800,
    ST_Z6   = 17'h01000,
    ST_Z7   = 17'h02000,
    ST_Z8   = 17'h04000,
    ST_Z9   = 17'h08000,
    ST_OUT  = 17'h10000
  } state_t;

  // step phases: address settle, issue, wait for result
  typedef enum logic [2:0] {
    PH_SETTLE = 3'b001,
    PH_ISSUE  = 3'b010,
    PH_WAIT   = 3'b100
  } phase_t;

  state_t         state, state_next;
  phase_t         phase, phase_next;
  logic [AW-1:0]  i_next, j_next;
  logic [ITW-1:0] it, it_next;
  logic           first, first_next;
  logic           i_last, j_last, it_last, compute, step_done;

  assign i_last  = ({1'b0, i} == (n - (AW + 1)'(1)));
  assign j_last  = ({1'b0, j} == (n - (AW + 1)'(1)));
  assign it_last = (it == ITW'(ITERATIONS - 1));
  assign compute = !((state == ST_IDLE) || (state == ST_XCLR) || (state == ST_OUT));
  assign step_done = compute && (phase == PH_WAIT) && stat.fpu_done;
  assign in_ready = (state == ST_IDLE);
  assign vaddr = ((state == ST_XMUL) || (state == ST_XACC)) ? j : i;

  // command decode
  always_comb begin
    cmd = cmd_t'('0);
    cmd.op = FOP_ADD;
    cmd.src_a = SRC_ACC;
    cmd.src_b = SRC_TMP;
    cmd.dst = DST_NONE;
    cmd.first = first;
    cmd.start = compute && (phase == PH_ISSUE);
    cmd.load = (state == ST_IDLE) && in_valid;
    cmd.out_load = (state == ST_OUT) && (phase == PH_ISSUE) && stat.out_free;
    cmd.out_last = i_last;
    unique case (state)
      ST_BETA: begin
        cmd.op = FOP_SUB; cmd.src_a = SRC_ONE; cmd.src_b = SRC_ALPHA; cmd.dst = DST_BETA;
      end
      ST_W: begin
        cmd.op = FOP_SUB; cmd.src_a = SRC_ZOLD; cmd.src_b = SRC_U; cmd.we_w = 1'b1;
      end
      ST_XCLR: cmd.clr_acc = 1'b1;
      ST_XMUL: begin
        cmd.op = FOP_MUL; cmd.src_a = SRC_MAT; cmd.src_b = SRC_W; cmd.dst = DST_TMP;
      end
      ST_XACC: begin
        cmd.src_a = SRC_ACC; cmd.src_b = SRC_TMP; cmd.dst = DST_ACC;
      end
      ST_XQ: begin
        cmd.src_a = SRC_ACC; cmd.src_b = SRC_Q; cmd.we_x = 1'b1;
      end
      ST_Z1: begin
        cmd.op = FOP_MUL; cmd.src_a = SRC_ALPHA; cmd.src_b = SRC_X; cmd.dst = DST_TMP;
        cmd.we_zold = 1'b1;
      end
      ST_Z2: begin
        cmd.op = FOP_MUL; cmd.src_a = SRC_BETA; cmd.src_b = SRC_Z; cmd.dst = DST_ACC;
      end
      ST_Z3: begin
        cmd.src_a = SRC_TMP; cmd.src_b = SRC_ACC; cmd.dst = DST_XH;
      end
      ST_Z4: begin
        cmd.src_a = SRC_XH; cmd.src_b = SRC_U; cmd.dst = DST_V;
      end
      ST_Z5: begin
        cmd.op = FOP_SUB; cmd.src_a = SRC_V; cmd.src_b = SRC_RHO; cmd.dst = DST_TMP;
        cmd.clamp = 1'b1;
      end
      ST_Z6: begin
        cmd.op = FOP_SUB; cmd.src_a = SRC_V; cmd.neg_a = 1'b1; cmd.src_b = SRC_RHO;
        cmd.dst = DST_ACC; cmd.clamp = 1'b1;
      end
      ST_Z7: begin
        cmd.op = FOP_SUB; cmd.src_a = SRC_TMP; cmd.src_b = SRC_ACC; cmd.dst = DST_ZR;
        cmd.we_z = 1'b1;
      end
      ST_Z8: begin
        cmd.op = FOP_SUB; cmd.src_a = SRC_XH; cmd.src_b = SRC_ZR; cmd.dst = DST_TMP;
      end
      ST_Z9: begin
        cmd.src_a = SRC_U; cmd.src_b = SRC_TMP; cmd.we_u = 1'b1;
      end
      default: ;
    endcase
  end

  // sequencing
  always_comb begin
    state_next = state;
    phase_next = phase;
    i_next     = i;
    j_next     = j;
    it_next    = it;
    first_next = first;
    if (compute) begin
      unique case (phase)
        PH_SETTLE: phase_next = PH_ISSUE;
        PH_ISSUE:  phase_next = PH_WAIT;
        PH_WAIT:   if (stat.fpu_done) phase_next = PH_SETTLE;
        default:   phase_next = PH_SETTLE;
      endcase
    end
    unique case (state)
      ST_IDLE: begin
        if (in_valid && in_last) begin
          state_next = ST_BETA;
          phase_next = PH_SETTLE;
          i_next = '0;
          it_next = '0;
          first_next = 1'b1;
        end
      end
      ST_BETA: if (step_done) state_next = ST_W;
      ST_W: begin
        if (step_done) begin
          if (i_last) begin
            i_next = '0;
            state_next = ST_XCLR;
          end else begin
            i_next = i + AW'(1);
          end
        end
      end
      ST_XCLR: begin
        j_next = '0;
        state_next = ST_XMUL;
      end
      ST_XMUL: if (step_done) state_next = ST_XACC;
      ST_XACC: begin
        if (step_done) begin
          if (j_last) begin
            state_next = ST_XQ;
          end else begin
            j_next = j + AW'(1);
            state_next = ST_XMUL;
          end
        end
      end
      ST_XQ: begin
        if (step_done) begin
          if (i_last) begin
            i_next = '0;
            state_next = ST_Z1;
          end else begin
            i_next = i + AW'(1);
            state_next = ST_XCLR;
          end
        end
      end
      ST_Z1: if (step_done) state_next = ST_Z2;
      ST_Z2: if (step_done) state_next = ST_Z3;
      ST_Z3: if (step_done) state_next = ST_Z4;
      ST_Z4: if (step_done) state_next = ST_Z5;
      ST_Z5: if (step_done) state_next = ST_Z6;
      ST_Z6: if (step_done) state_next = ST_Z7;
      ST_Z7: if (step_done) state_next = ST_Z8;
      ST_Z8: if (step_done) state_next = ST_Z9;
      ST_Z9: begin
        if (step_done) begin
          if (i_last) begin
            i_next = '0;
            if (it_last) begin
              state_next = ST_OUT;
            end else begin
              it_next = it + ITW'(1);
              first_next = 1'b0;
              state_next = ST_W;
            end
          end else begin
            i_next = i + AW'(1);
            state_next = ST_Z1;
          end
        end
      end
      ST_OUT: begin
        if (phase == PH_SETTLE) begin
          phase_next = PH_ISSUE;
        end else if (stat.out_free) begin
          phase_next = PH_SETTLE;
          if (i_last) begin
            state_next = ST_IDLE;
          end else begin
            i_next = i + AW'(1);
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= PH_SETTLE;
      i     <= '0;
      j     <= '0;
      it    <= '0;
      first <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      i     <= i_next;
      j     <= j_next;
      it    <= it_next;
      first <= first_next;
    end
  end

  `ASSERT_PROP(a_start_single, clk, rst, cmd.start |=> !cmd.start)
  `ASSERT_PROP(a_done_in_wait, clk, rst, stat.fpu_done |-> (phase == PH_WAIT))

endmodule

/* hw/rtl/admm_soft_threshold_solver_core.sv */
`timescale 1ns / 1ps
// Over-relaxed ADMM solver with soft thresholding, IEEE single precision.
// Input stream: each transaction writes one matrix element (tuser = 0) at
// (row, col) or one q element (tuser = 1) at row. The transaction with
// tlast set starts a solve after its element is stored.
// Config channel: cfg_index 0 = rho, 1 = alpha, 2 = problem size n; write
// only while no solve is running. Always ready.
// Output stream: n transactions, one per x element in index order, tlast on
// the last one.
// Loads are accepted back to back while idle. A solve runs one shared
// five-stage add/multiply unit, one operation at a time; solve time is set
// by the serial dot-product accumulation. Output elements are then loaded
// one at a time, each once the output register is free.
// Input is not accepted during a solve or while results are being emitted.
// A stalled output holds in its register and the emit sequence waits.
// Reset (synchronous) returns to idle and restores register defaults; the
// matrix and q stores keep their contents.
module admm_soft_threshold_solver_core #(
  parameter int DIM        = 64,
  parameter int ITERATIONS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // row[5:0], col[11:6], value[43:12], zero pad
  input  logic [0:0]  s_axis_tuser,   // mode[0]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // index[5:0], solution[37:6], zero pad
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import admm_pkg::*;

  localparam int AW = (DIM > 1) ? $clog2(DIM) : 1;

  cmd_t          cmd;
  stat_t         stat;
  logic [AW-1:0] i, j, vaddr;
  logic [AW:0]   n;
  logic [5:0]    out_index;
  logic [31:0]   out_solution;

  assign cfg_ready = 1'b1;

  admm_ctrl #(
    .DIM        (DIM),
    .ITERATIONS (ITERATIONS),
    .AW         (AW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_last  (s_axis_tlast),
    .in_ready (s_axis_tready),
    .n        (n),
    .stat     (stat),
    .cmd      (cmd),
    .i        (i),
    .j        (j),
    .vaddr    (vaddr)
  );

  admm_datapath #(
    .DIM (DIM),
    .AW  (AW)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .i            (i),
    .j            (j),
    .vaddr        (vaddr),
    .n            (n),
    .cfg_write    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .load_mode    (s_axis_tuser[0]),
    .load_row     (s_axis_tdata[5:0]),
    .load_col     (s_axis_tdata[11:6]),
    .load_value   (s_axis_tdata[43:12]),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_index    (out_index),
    .out_solution (out_solution),
    .out_end      (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, out_solution, out_index};

endmodule

/* tb/sv/tb_admm_soft_threshold_solver_core.sv */
`timescale 1ns / 1ps
module tb_admm_soft_threshold_solver_core;
  import admm_pkg::*;

  localparam int DIM        = 64;
  localparam int ITERATIONS = 32;
  localparam int IDLE_WAIT  = 40;

  typedef struct {
    logic [5:0]  index;
    logic [31:0] solution;
    logic        end_of_run;
  } x_elem_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;   // row[5:0], col[11:6], value[43:12], zero pad
  logic [0:0]  s_axis_tuser;   // mode[0]
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // index[5:0], solution[37:6], zero pad
  logic        m_axis_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  // mirror of the block state
  logic [31:0] mat_mem [DIM][DIM];
  logic [31:0] q_mem [DIM];
  logic [31:0] rho_q, alpha_q;
  logic [6:0]  dim_q;

  x_elem_t pending_x [$];
  int errors;
  int solves;
  int checked;
  int burst_left;
  bit gaps_on;
  int hold_cycles;
  int stall_pct;
  int rx_cyc;

  admm_soft_threshold_solver_core #(
    .DIM(DIM),
    .ITERATIONS(ITERATIONS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------- single precision arithmetic ----------------

  function automatic bit is_nan(logic [31:0] a);
    return a[30:23] == 8'hFF && a[22:0] != 0;
  endfunction

  function automatic bit is_inf(logic [31:0] a);
    return a[30:23] == 8'hFF && a[22:0] == 0;
  endfunction

  // round mag * 2^scale to nearest even
  function automatic logic [31:0] f32_pack(logic sgn, int scale, logic [127:0] mag);
    int p;
    int sh;
    int lsb_exp;
    logic [127:0] qv;
    logic rb, st;
    longint bits;
    if (mag == 0) return {sgn, 31'b0};
    p = 0;
    for (int k = 0; k < 128; k++) if (mag[k]) p = k;
    sh = p - 23;
    if (sh < -149 - scale) sh = -149 - scale;
    rb = 1'b0;
    st = 1'b0;
    if (sh <= 0) begin
      qv = mag << (-sh);
    end else if (sh > 120) begin
      qv = 0;
      st = 1'b1;
    end else begin
      qv = mag >> sh;
      rb = mag[sh-1];
      st = (mag & ((128'd1 << (sh - 1)) - 1)) != 0;
    end
    lsb_exp = scale + sh;
    if (rb && (st || qv[0])) qv = qv + 1;
    if (qv == 0) return {sgn, 31'b0};
    bits = (longint'(lsb_exp + 149) << 23) + longint'(qv[31:0]);
    if (bits >= 64'h7F80_0000) return {sgn, 31'h7F80_0000};
    return {sgn, bits[30:0]};
  endfunction

  function automatic logic [31:0] f32_add(logic [31:0] a, logic [31:0] b);
    logic [31:0] t;
    int ea, eb, d;
    logic [127:0] ma, mb, lost, r;
    if (is_nan(a) || is_nan(b)) return FP_DEFAULT_NAN;
    if (is_inf(a) && is_inf(b)) return (a[31] != b[31]) ? FP_DEFAULT_NAN : a;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    if (a[30:0] == 0 && b[30:0] == 0) return {a[31] & b[31], 31'b0};
    if (a[30:0] == 0) return b;
    if (b[30:0] == 0) return a;
    if (b[30:0] > a[30:0]) begin
      t = a;
      a = b;
      b = t;
    end
    ea = (a[30:23] == 0) ? 1 : int'(a[30:23]);
    eb = (b[30:23] == 0) ? 1 : int'(b[30:23]);
    ma = 128'({a[30:23] != 0, a[22:0]}) << 40;
    mb = 128'({b[30:23] != 0, b[22:0]}) << 40;
    d = ea - eb;
    if (d >= 100) begin
      mb = 1;
    end else if (d > 0) begin
      lost = mb & ((128'd1 << d) - 1);
      mb = (mb >> d) | 128'(lost != 0);
    end
    r = (a[31] == b[31]) ? ma + mb : ma - mb;
    if (r == 0) return FP_ZERO;
    return f32_pack(a[31], ea - 150 - 40, r);
  endfunction

  function automatic logic [31:0] f32_sub(logic [31:0] a, logic [31:0] b);
    return f32_add(a, {~b[31], b[30:0]});
  endfunction

  function automatic logic [31:0] f32_mul(logic [31:0] a, logic [31:0] b);
    logic sgn;
    int ea, eb;
    logic [127:0] m;
    sgn = a[31] ^ b[31];
    if (is_nan(a) || is_nan(b)) return FP_DEFAULT_NAN;
    if (is_inf(a) || is_inf(b)) begin
      if (a[30:0] == 0 || b[30:0] == 0) return FP_DEFAULT_NAN;
      return {sgn, 31'h7F80_0000};
    end
    if (a[30:0] == 0 || b[30:0] == 0) return {sgn, 31'b0};
    ea = (a[30:23] == 0) ? 1 : int'(a[30:23]);
    eb = (b[30:23] == 0) ? 1 : int'(b[30:23]);
    m = 128'({a[30:23] != 0, a[22:0]}) * 128'({b[30:23] != 0, b[22:0]});
    return f32_pack(sgn, (ea - 150) + (eb - 150), m);
  endfunction

  function automatic bit f32_pos(logic [31:0] a);
    return !a[31] && a[30:0] != 0 && !is_nan(a);
  endfunction

  // ---------------- solver prediction ----------------

  task automatic solve_admm();
    logic [31:0] x [DIM];
    logic [31:0] z [DIM];
    logic [31:0] zold [DIM];
    logic [31:0] u [DIM];
    logic [31:0] w [DIM];
    logic [31:0] xh [DIM];
    logic [31:0] acc, beta, v, s0, s1;
    x_elem_t e;
    int n;
    n = int'(dim_q);
    if (n < 1) n = 1;
    if (n > DIM) n = DIM;
    beta = f32_sub(FP_ONE, alpha_q);
    for (int i = 0; i < DIM; i++) begin
      x[i] = FP_ZERO;
      z[i] = FP_ZERO;
      zold[i] = FP_ZERO;
      u[i] = FP_ZERO;
    end
    for (int it = 0; it < ITERATIONS; it++) begin
      for (int i = 0; i < n; i++) w[i] = f32_sub(zold[i], u[i]);
      for (int i = 0; i < n; i++) begin
        acc = FP_ZERO;
        for (int j = 0; j < n; j++) acc = f32_add(acc, f32_mul(mat_mem[i][j], w[j]));
        x[i] = f32_add(acc, q_mem[i]);
      end
      for (int i = 0; i < n; i++) zold[i] = z[i];
      for (int i = 0; i < n; i++)
        xh[i] = f32_add(f32_mul(alpha_q, x[i]), f32_mul(beta, zold[i]));
      // soft threshold
      for (int i = 0; i < n; i++) begin
        v = f32_add(xh[i], u[i]);
        s0 = f32_sub(v, rho_q);
        s1 = f32_sub({~v[31], v[30:0]}, rho_q);
        z[i] = f32_sub(f32_pos(s0) ? s0 : FP_ZERO, f32_pos(s1) ? s1 : FP_ZERO);
      end
      for (int i = 0; i < n; i++) u[i] = f32_add(u[i], f32_sub(xh[i], z[i]));
    end
    for (int i = 0; i < n; i++) begin
      e.index = 6'(i);
      e.solution = x[i];
      e.end_of_run = (i == n - 1);
      pending_x.push_back(e);
    end
    solves++;
  endtask

  // ---------------- drivers ----------------

  task automatic send_item(logic mode, logic [5:0] row, logic [5:0] col,
                           logic [31:0] value, logic last);
    if (burst_left == 0) begin
      if (gaps_on) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, value, col, row};
    s_axis_tuser <= mode;
    s_axis_tlast <= last;
    do @(posedge clk); while (!s_axis_tready);
    if (mode == 1'b0) mat_mem[row][col] = value;
    else q_mem[row] = value;
    if (last) solve_admm();
  endtask

  task automatic end_burst();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
  endtask

  task automatic wait_idle();
    while (pending_x.size() != 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_reg_t idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_RHO: rho_q = data;
      CFG_ALPHA: alpha_q = data;
      default: dim_q = data[6:0];
    endcase
  endtask

  function automatic logic [31:0] moderate_value(int lo_exp, int hi_exp);
    return {1'($urandom_range(0, 1)), 8'($urandom_range(lo_exp, hi_exp)), 23'($urandom)};
  endfunction

  // load a full n x n problem, last on the final q element
  task automatic load_problem(int n, int lo_exp, int hi_exp, bit wild);
    logic [31:0] v;
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++) begin
        v = (wild && $urandom_range(0, 3) == 0) ? $urandom : moderate_value(lo_exp, hi_exp);
        send_item(1'b0, 6'(r), 6'(c), v, 1'b0);
      end
    for (int r = 0; r < n; r++) begin
      v = (wild && $urandom_range(0, 3) == 0) ? $urandom : moderate_value(120, 129);
      send_item(1'b1, 6'(r), 6'($urandom), v, r == n - 1);
    end
  endtask

  // ---------------- tests ----------------

  task automatic test_scalar_extremes();
    logic [31:0] vals [12];
    vals = '{32'h0000_0000, 32'h8000_0000, FP_ONE, 32'h7F7F_FFFF, 32'hFF7F_FFFF,
             32'h0000_0001, 32'h807F_FFFF, 32'h7F80_0000, 32'hFF80_0000,
             32'h7FC0_0000, 32'hFFFF_FFFF, 32'hBF80_0000};
    cfg_write(CFG_DIMENSION, 32'd1);
    cfg_write(CFG_RHO, 32'h0000_0000);
    cfg_write(CFG_ALPHA, FP_ONE);
    // far corners are stored but never read at n = 1
    send_item(1'b0, 6'd63, 6'd63, 32'hFFFF_FFFF, 1'b0);
    send_item(1'b1, 6'd63, 6'd63, 32'h0000_0000, 1'b0);
    send_item(1'b0, 6'd0, 6'd0, 32'h3F00_0000, 1'b0);
    for (int k = 0; k < 12; k++) begin
      send_item(1'b1, 6'd0, 6'(k * 5), vals[k], 1'b0);
      send_item(1'b0, 6'd0, 6'd0, vals[(k + 3) % 12], 1'b1);
    end
    end_burst();
    wait_idle();
    // size zero behaves as one
    cfg_write(CFG_DIMENSION, 32'd0);
    send_item(1'b1, 6'd0, 6'd0, 32'h4040_0000, 1'b1);
    end_burst();
    wait_idle();
  endtask

  task automatic test_register_extremes();
    cfg_write(CFG_DIMENSION, 32'd3);
    cfg_write(CFG_RHO, 32'h3F00_0000);
    cfg_write(CFG_ALPHA, 32'h3FC0_0000);
    load_problem(3, 118, 124, 1'b0);
    end_burst();
    wait_idle();
    cfg_write(CFG_RHO, 32'hFFFF_FFFF);
    cfg_write(CFG_ALPHA, 32'h0000_0000);
    send_item(1'b1, 6'd2, 6'd0, 32'h3F80_0000, 1'b1);
    end_burst();
    wait_idle();
    cfg_write(CFG_RHO, 32'h7F80_0000);
    cfg_write(CFG_ALPHA, 32'hFFFF_FFFF);
    send_item(1'b1, 6'd1, 6'd0, 32'hC000_0000, 1'b1);
    end_burst();
    wait_idle();
  endtask

  task automatic test_random_solves();
    int n;
    for (int s = 0; s < 4; s++) begin
      n = $urandom_range(2, 3);
      gaps_on = (s % 3 != 2);
      cfg_write(CFG_DIMENSION, 32'(n));
      cfg_write(CFG_RHO, $urandom_range(0, 4) == 0 ? $urandom : moderate_value(110, 125) & 32'h7FFF_FFFF);
      cfg_write(CFG_ALPHA, $urandom_range(0, 4) == 0 ? $urandom : {9'h07F, 23'($urandom)});
      // noise outside the active block
      repeat ($urandom_range(0, 3))
        send_item(1'($urandom), 6'($urandom_range(n, 63)), 6'($urandom), $urandom, 1'b0);
      if (s == 1) hold_cycles = 20000;
      load_problem(n, 116, 125, s == 3);
      if (s == 1) begin
        // keep offering the next problem while the output is held off
        load_problem(n, 116, 125, 1'b0);
      end
      end_burst();
      wait_idle();
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_larger_size();
    cfg_write(CFG_DIMENSION, 32'd5);
    cfg_write(CFG_RHO, 32'h3C23_D70A);
    cfg_write(CFG_ALPHA, 32'h3FB3_3333);
    load_problem(5, 105, 115, 1'b0);
    end_burst();
    wait_idle();
  endtask

  // ---------------- result checking and output stall ----------------

  always @(posedge clk) begin
    x_elem_t e;
    logic [5:0] got_idx;
    logic [31:0] got_x;
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_cyc <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_idx = m_axis_tdata[5:0];
        got_x = m_axis_tdata[37:6];
        if (pending_x.size() == 0) begin
          $display("%0t: unexpected x transaction: index %0d x %h last %b",
                   $time, got_idx, got_x, m_axis_tlast);
          errors++;
        end else begin
          e = pending_x.pop_front();
          checked++;
          if (got_idx != e.index) begin
            $display("%0t: index mismatch: expected %0d actual %0d", $time, e.index, got_idx);
            errors++;
          end
          if (got_x != e.solution && !(is_nan(got_x) && is_nan(e.solution))) begin
            $display("%0t: x[%0d] mismatch: expected %h actual %h",
                     $time, e.index, e.solution, got_x);
            errors++;
          end
          if (m_axis_tlast != e.end_of_run) begin
            $display("%0t: tlast mismatch at x[%0d]: expected %b actual %b",
                     $time, e.index, e.end_of_run, m_axis_tlast);
            errors++;
          end
        end
      end
      rx_cyc <= rx_cyc + 1;
      if (rx_cyc % 256 == 0) stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 80);
      if (hold_cycles > 0) begin
        hold_cycles = hold_cycles - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // ---------------- run ----------------

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    s_axis_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_RHO;
    cfg_data = '0;
    errors = 0;
    solves = 0;
    checked = 0;
    burst_left = 0;
    gaps_on = 1'b1;
    hold_cycles = 0;
    stall_pct = 0;
    rho_q = RHO_RESET;
    alpha_q = ALPHA_RESET;
    dim_q = DIMENSION_RESET;
    for (int r = 0; r < DIM; r++) begin
      q_mem[r] = FP_ZERO;
      for (int c = 0; c < DIM; c++) mat_mem[r][c] = FP_ZERO;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_scalar_extremes();
    test_register_extremes();
    test_random_solves();
    test_larger_size();

    while (pending_x.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Ran %0d solves (sizes 1 to 5, special floats, register extremes)", solves);
    $display("and compared %0d solution transactions, %0d mismatches", checked, errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #60_000_000;
    $display("Timeout with %0d solution transactions outstanding", pending_x.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/admm_pkg.sv
hw/rtl/admm_fpu.sv
hw/rtl/admm_datapath.sv
hw/rtl/admm_ctrl.sv
hw/rtl/admm_soft_threshold_solver_core.sv
tb/sv/tb_admm_soft_threshold_solver_core.sv
